[rtl/core/alu32f_pkg.sv]
package alu32f_pkg;

   localparam int DataWidthDefault = 32;
   localparam int ActionWidth      = 4;

   localparam logic [ActionWidth-1:0] ACT_ADD = 4'd0;
   localparam logic [ActionWidth-1:0] ACT_SUB = 4'd1;
   localparam logic [ActionWidth-1:0] ACT_MUL = 4'd2;
   localparam logic [ActionWidth-1:0] ACT_DIV = 4'd3;
   localparam logic [ActionWidth-1:0] ACT_AND = 4'd4;
   localparam logic [ActionWidth-1:0] ACT_OR  = 4'd5;
   localparam logic [ActionWidth-1:0] ACT_XOR = 4'd6;
   localparam logic [ActionWidth-1:0] ACT_NOT = 4'd7;
   localparam logic [ActionWidth-1:0] ACT_SHL = 4'd8;
   localparam logic [ActionWidth-1:0] ACT_SAR = 4'd9;

endpackage

[rtl/core/alu_32bit_with_flags.sv]
// Integer ALU with zero, negative, carry and overflow flags.
// Input channel req_*: action code and two signed operands, one beat per
// item. Result channel rsp_*: value and the four flags, one beat per item,
// in the order the items were taken.
// A req beat reaches rsp_valid through DATA_WIDTH + 2 register stages: one
// entry stage (add/sub/logic/shift done, full product formed, divide
// operands turned to magnitudes), DATA_WIDTH restoring divide stages (the
// first also folds in the product and its overflow), and one stage that
// signs the quotient; the zero and negative flags are formed from its
// output. The divider sets the depth; every action goes through the same
// stages so results stay in order.
// Throughput is one item per cycle while rsp_ready is high.
// When rsp_ready is low with a result waiting, the whole pipeline holds and
// req_ready drops; nothing is lost or repeated. Empty stages do not gate
// the hold.
// Reset clears all stage valid bits; the pipeline comes up empty and
// ready. Action codes 10 to 15 give value 0 with only the zero flag set.
module alu_32bit_with_flags #(
   parameter int DATA_WIDTH = alu32f_pkg::DataWidthDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [alu32f_pkg::ActionWidth-1:0]    req_action,
   input  logic signed [DATA_WIDTH-1:0]          req_operand_a,
   input  logic signed [DATA_WIDTH-1:0]          req_operand_b,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [DATA_WIDTH-1:0]          rsp_value,
   output logic                                  rsp_zero_flag,
   output logic                                  rsp_negative_flag,
   output logic                                  rsp_carry_flag,
   output logic                                  rsp_overflow_flag
);
   import alu32f_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int SW = $clog2(W);
   localparam int NS = W + 2;
   localparam logic [W-1:0] WIDTH_U = W'(W);
   localparam logic [W-1:0] MIN_U   = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic [ActionWidth-1:0] act;
      logic [W-1:0]           res;
      logic                   c;
      logic                   v;
      logic [W-1:0]           rem;
      logic [W-1:0]           quo;
      logic [W-1:0]           dvs;
      logic                   qneg;
      logic                   dspec;
   } stage_type;

   stage_type          st_ff [NS];
   stage_type          st_in [NS];
   stage_type          step_src [1:W];
   logic [NS-1:0]      vld_ff;
   logic [2*W-1:0]     prod_ff;
   logic [2*W-1:0]     prod_in;
   logic               en;

   assign en        = !vld_ff[NS-1] || rsp_ready;
   assign req_ready = en;

   // entry stage
   logic [W-1:0]        ua, ub, ma, mb;
   logic [W:0]          sum;
   logic [W-1:0]        dif;
   logic [W:0]          shl_w;
   logic signed [W:0]   sar_w;
   logic [SW-1:0]       shn;
   logic                sh_none, sh_sat;

   always_comb begin
      ua      = req_operand_a;
      ub      = req_operand_b;
      ma      = ua[W-1] ? (~ua + 1'b1) : ua;
      mb      = ub[W-1] ? (~ub + 1'b1) : ub;
      sum     = {1'b0, ua} + {1'b0, ub};
      dif     = ua - ub;
      shn     = ub[SW-1:0];
      shl_w   = {1'b0, ua} << shn;
      sar_w   = $signed({ua, 1'b0}) >>> shn;
      sh_none = ub[W-1] || (ub == '0);
      sh_sat  = !sh_none && (ub >= WIDTH_U);
      prod_in = (2*W)'($signed(req_operand_a) * $signed(req_operand_b));

      st_in[0]       = '0;
      st_in[0].act   = req_action;
      st_in[0].rem   = '0;
      st_in[0].quo   = ma;
      st_in[0].dvs   = mb;
      st_in[0].qneg  = ua[W-1] ^ ub[W-1];
      case (req_action)
         ACT_ADD: begin
            st_in[0].res = sum[W-1:0];
            st_in[0].c   = sum[W];
            st_in[0].v   = (ua[W-1] ^ sum[W-1]) & (ub[W-1] ^ sum[W-1]);
         end
         ACT_SUB: begin
            st_in[0].res = dif;
            st_in[0].c   = ua < ub;
            st_in[0].v   = (ua[W-1] ^ ub[W-1]) & (ua[W-1] ^ dif[W-1]);
         end
         ACT_DIV: begin
            if (ub == '0) begin
               st_in[0].dspec = 1'b1;
               st_in[0].v     = 1'b1;
            end else if (ua == MIN_U && ub == '1) begin
               st_in[0].dspec = 1'b1;
               st_in[0].v     = 1'b1;
               st_in[0].res   = MIN_U;
            end
         end
         ACT_AND: st_in[0].res = ua & ub;
         ACT_OR:  st_in[0].res = ua | ub;
         ACT_XOR: st_in[0].res = ua ^ ub;
         ACT_NOT: st_in[0].res = ~ua;
         ACT_SHL: begin
            if (sh_none) begin
               st_in[0].res = ua;
            end else if (!sh_sat) begin
               st_in[0].res = shl_w[W-1:0];
               st_in[0].c   = shl_w[W];
            end
         end
         ACT_SAR: begin
            if (sh_none) begin
               st_in[0].res = ua;
            end else if (sh_sat) begin
               st_in[0].res = {W{ua[W-1]}};
            end else begin
               st_in[0].res = sar_w[W:1];
               st_in[0].c   = sar_w[0];
            end
         end
         default: st_in[0].res = '0;
      endcase
   end

   // product folds in ahead of the first divide step
   logic [W:0] prod_hi;
   always_comb begin
      prod_hi     = prod_ff[2*W-1:W-1];
      step_src[1] = st_ff[0];
      if (st_ff[0].act == ACT_MUL) begin
         step_src[1].res = prod_ff[W-1:0];
         step_src[1].v   = !((&prod_hi) || !(|prod_hi));
      end
   end

   // one restoring divide step per stage
   for (genvar k = 1; k <= W; k++) begin : g_div
      if (k > 1) begin : g_src
         assign step_src[k] = st_ff[k-1];
      end
      logic [W-1:0] trial;
      logic         ge;
      always_comb begin
         trial    = {step_src[k].rem[W-2:0], step_src[k].quo[W-1]};
         ge       = trial >= step_src[k].dvs;
         st_in[k] = step_src[k];
         st_in[k].rem = ge ? (trial - step_src[k].dvs) : trial;
         st_in[k].quo = {step_src[k].quo[W-2:0], ge};
      end
   end

   // final stage: sign the quotient
   always_comb begin
      st_in[NS-1] = st_ff[NS-2];
      if (st_ff[NS-2].act == ACT_DIV && !st_ff[NS-2].dspec) begin
         st_in[NS-1].res = st_ff[NS-2].qneg ? (~st_ff[NS-2].quo + 1'b1)
                                            : st_ff[NS-2].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         for (int i = 0; i < NS; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign rsp_valid         = vld_ff[NS-1];
   assign rsp_value         = st_ff[NS-1].res;
   assign rsp_zero_flag     = (st_ff[NS-1].res == '0);
   assign rsp_negative_flag = st_ff[NS-1].res[W-1];
   assign rsp_carry_flag    = st_ff[NS-1].c;
   assign rsp_overflow_flag = st_ff[NS-1].v;

`ifndef SYNTH
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("stage valids moved during stall");

   a_carry_actions: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_carry_flag |-> st_ff[NS-1].act == ACT_ADD ||
         st_ff[NS-1].act == ACT_SUB || st_ff[NS-1].act == ACT_SHL ||
         st_ff[NS-1].act == ACT_SAR)
      else $error("carry set for an action without carry");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && st_ff[NS-1].act == ACT_DIV && st_ff[NS-1].dspec
         |-> rsp_overflow_flag)
      else $error("divide special case without overflow");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");
`endif

endmodule
